// ===== rtl/ptt_pkg.sv =====
// Shared constants and types for the priority thread table.
package ptt_pkg;

  localparam int unsigned MaxThreadsDefault = 16;

  localparam int unsigned IdWidth   = 32;
  localparam int unsigned PrioWidth = 8;
  localparam int unsigned CmdWidth  = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_CREATE = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic start;
    logic scan_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_done;
  } dp_status_t;

endpackage

// ===== rtl/ptt_in_if.sv =====
// Request channel: command beat with valid/ready handshake.
interface ptt_in_if;
  logic                          valid;
  logic                          ready;
  logic [ptt_pkg::CmdWidth-1:0]  command;
  logic [ptt_pkg::PrioWidth-1:0] priority_req;
  logic [ptt_pkg::IdWidth-1:0]   target_id;

  modport source (output valid, output command, output priority_req, output target_id,
                  input ready);
  modport sink   (input valid, input command, input priority_req, input target_id,
                  output ready);
endinterface

// ===== rtl/ptt_out_if.sv =====
// Response channel: status and thread id beat with valid/ready handshake.
interface ptt_out_if;
  logic                        valid;
  logic                        ready;
  logic                        status;
  logic [ptt_pkg::IdWidth-1:0] result_id;

  modport source (output valid, output status, output result_id, input ready);
  modport sink   (input valid, input status, input result_id, output ready);
endinterface

// ===== rtl/ptt_ctrl.sv =====
// Sequencer for the priority thread table: accept, table scan, commit.
module ptt_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [ptt_pkg::CmdWidth-1:0] in_cmd_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  ptt_pkg::dp_status_t          status_i,
  output ptt_pkg::ctrl_cmd_t           cmd_o
);
  import ptt_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          if (in_cmd_i == CMD_DELETE || in_cmd_i == CMD_FIND) begin
            state_d = StScan;
          end else begin
            state_d = StDone;
          end
        end
      end
      StScan: begin
        cmd_o.scan_en = 1'b1;
        if (status_i.scan_done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== rtl/ptt_dp.sv =====
// Datapath: thread table memory, entry count, id counter, scan and result registers.
module ptt_dp #(
  parameter int unsigned MAX_THREADS = ptt_pkg::MaxThreadsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptt_pkg::ctrl_cmd_t            cmd_i,
  output ptt_pkg::dp_status_t           status_o,
  input  logic [ptt_pkg::CmdWidth-1:0]  command_i,
  input  logic [ptt_pkg::PrioWidth-1:0] priority_req_i,
  input  logic [ptt_pkg::IdWidth-1:0]   target_id_i,
  output logic                          status_o_bit_o,
  output logic [ptt_pkg::IdWidth-1:0]   result_id_o
);
  import ptt_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_THREADS);
  localparam int unsigned CntW = $clog2(MAX_THREADS + 1);

  logic [IdWidth-1:0]   id_mem_q   [MAX_THREADS];
  logic [PrioWidth-1:0] prio_mem_q [MAX_THREADS];

  logic [CmdWidth-1:0]  cmd_q;
  logic [PrioWidth-1:0] prio_q;
  logic [IdWidth-1:0]   target_q;
  logic [CntW-1:0]      count_q, count_d;
  logic [IdWidth-1:0]   id_ctr_q, id_ctr_d;
  logic [CntW-1:0]      issue_q;
  logic                 pend_q;
  logic [IdxW-1:0]      pend_idx_q;
  logic [IdWidth-1:0]   rd_id_q;
  logic [PrioWidth-1:0] rd_prio_q;
  logic                 found_q;
  logic [PrioWidth-1:0] best_prio_q;
  logic [IdWidth-1:0]   best_id_q;
  logic                 out_status_q;
  logic [IdWidth-1:0]   out_id_q;

  logic                 issue_go;
  logic                 match;
  logic                 shift_wr;
  logic                 better;
  logic                 full;
  logic                 create_wr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [IdWidth-1:0]   wr_id;
  logic [PrioWidth-1:0] wr_prio;

  assign issue_go  = cmd_i.scan_en && (issue_q != count_q);
  assign match     = pend_q && !found_q && (cmd_q == CMD_DELETE) && (rd_id_q == target_q);
  assign shift_wr  = pend_q && found_q && (cmd_q == CMD_DELETE);
  assign better    = pend_q && (cmd_q == CMD_FIND) && (rd_prio_q > best_prio_q);
  assign full      = (count_q == CntW'(MAX_THREADS));
  assign create_wr = cmd_i.commit && (cmd_q == CMD_CREATE) && !full;

  // entries after the removed one move down by one slot as they stream past
  assign wr_en   = shift_wr || create_wr;
  assign wr_addr = shift_wr ? (pend_idx_q - IdxW'(1)) : count_q[IdxW-1:0];
  assign wr_id   = shift_wr ? rd_id_q : id_ctr_q;
  assign wr_prio = shift_wr ? rd_prio_q : prio_q;

  assign status_o.scan_done = (issue_q == count_q) && !pend_q;

  assign status_o_bit_o = out_status_q;
  assign result_id_o    = out_id_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      id_mem_q[wr_addr]   <= wr_id;
      prio_mem_q[wr_addr] <= wr_prio;
    end
    if (issue_go) begin
      rd_id_q   <= id_mem_q[issue_q[IdxW-1:0]];
      rd_prio_q <= prio_mem_q[issue_q[IdxW-1:0]];
    end
  end

  always_comb begin
    count_d  = count_q;
    id_ctr_d = id_ctr_q;
    if (create_wr) begin
      count_d  = count_q + CntW'(1);
      id_ctr_d = id_ctr_q + IdWidth'(1);
    end else if (cmd_i.commit && (cmd_q == CMD_DELETE) && found_q) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      id_ctr_q <= '0;
      issue_q  <= '0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      id_ctr_q <= id_ctr_d;
      if (cmd_i.start) begin
        issue_q <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else begin
        pend_q <= issue_go;
        if (issue_go) begin
          issue_q <= issue_q + CntW'(1);
        end
        if (match || better) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cmd_q       <= command_i;
      prio_q      <= priority_req_i;
      target_q    <= target_id_i;
      best_prio_q <= '0;
    end
    if (issue_go) begin
      pend_idx_q <= issue_q[IdxW-1:0];
    end
    if (better) begin
      best_prio_q <= rd_prio_q;
      best_id_q   <= rd_id_q;
    end
    if (cmd_i.commit) begin
      unique case (cmd_q)
        CMD_CREATE: begin
          out_status_q <= full ? STATUS_ERR : STATUS_OK;
          out_id_q     <= full ? '0 : id_ctr_q;
        end
        CMD_DELETE: begin
          out_status_q <= found_q ? STATUS_OK : STATUS_ERR;
          out_id_q     <= '0;
        end
        CMD_FIND: begin
          out_status_q <= found_q ? STATUS_OK : STATUS_ERR;
          out_id_q     <= found_q ? best_id_q : '0;
        end
        default: begin
          out_status_q <= STATUS_ERR;
          out_id_q     <= '0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/priority_thread_table_core.sv =====
// Priority thread table: create, delete by id and find highest priority over a slot memory.
// Create and unknown commands: no table scan; the result is registered on commit.
// Delete and find: the table is scanned one slot per cycle, then the result is committed.
// One command in flight; the next beat is taken once the sequencer is back in idle after commit.
// A result still waiting in the output register holds back the commit of the next one.
// Async active-low reset empties the table and zeroes the id counter; slots stay unset.
module priority_thread_table_core #(
  parameter int unsigned MAX_THREADS = ptt_pkg::MaxThreadsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ptt_in_if.sink    in_i,
  ptt_out_if.source out_o
);
  import ptt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ptt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_cmd_i    (in_i.command),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptt_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .command_i      (in_i.command),
    .priority_req_i (in_i.priority_req),
    .target_id_i    (in_i.target_id),
    .status_o_bit_o (out_o.status),
    .result_id_o    (out_o.result_id)
  );

endmodule
